// ===== src/wohd_pkg.sv =====
// Shared types and constants of the windowed onset hit detector.
// Used by wohd_win and windowed_onset_hit_detector; depends on nothing.
`default_nettype none
package wohd_pkg;

    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_THRESHOLD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TREND_THRESHOLD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VARIANCE_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY_FRAMES  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_FRAMES      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DETECTION_MODE     = 3'd6;

    localparam logic [2:0] MODE_PEAK     = 3'd0;
    localparam logic [2:0] MODE_TREND    = 3'd1;
    localparam logic [2:0] MODE_VARIANCE = 3'd2;
    localparam logic [2:0] MODE_VOTE     = 3'd3;

    localparam logic [6:0]  RST_WINDOW_SIZE        = 7'd16;
    localparam logic [15:0] RST_PEAK_THRESHOLD     = 16'd768;
    localparam logic [15:0] RST_TREND_THRESHOLD    = 16'd384;
    localparam logic [15:0] RST_VARIANCE_THRESHOLD = 16'd512;
    localparam logic [15:0] RST_REFRACTORY_FRAMES  = 16'd4;
    localparam logic [15:0] RST_WARMUP_FRAMES      = 16'd0;
    localparam logic [2:0]  RST_DETECTION_MODE     = 3'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SWEEP,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_FINISH
    } state_t;

    typedef enum logic [4:0] {
        STEP_MQ,
        STEP_SS,
        STEP_MC,
        STEP_A2,
        STEP_LHS,
        STEP_T2,
        STEP_T2M,
        STEP_RHS,
        STEP_TA,
        STEP_TB,
        STEP_TC,
        STEP_V1,
        STEP_V2,
        STEP_V3,
        STEP_V4,
        STEP_V5,
        STEP_V6,
        STEP_V7,
        STEP_V8,
        STEP_V9
    } mul_step_t;

    typedef struct packed {
        logic write;
        logic sweep;
    } win_ctl_t;

endpackage
`default_nettype wire

// ===== src/wohd_mul.sv =====
// Shared sequential multiplier: two bits of the second operand per cycle.
// Depends on nothing but its parameters.
`default_nettype none
module wohd_mul #(
    parameter int MW = 48,
    parameter int PW = 96
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [MW-1:0] a,
    input  wire logic [MW-1:0] b,
    output logic               done,
    output logic [PW-1:0]      prod
);

    logic          run_reg;
    logic [PW-1:0] a_sh_reg;
    logic [MW-1:0] b_sh_reg;
    logic [PW-1:0] acc_reg;
    logic [PW-1:0] pp;

    always_comb
    begin
        pp = (b_sh_reg[0] ? a_sh_reg : '0) + (b_sh_reg[1] ? (a_sh_reg << 1) : '0);
    end

    assign done = run_reg && (b_sh_reg == '0);
    assign prod = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
        end
        else if (done)
        begin
            run_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_sh_reg <= PW'(a);
            b_sh_reg <= b;
            acc_reg  <= '0;
        end
        else if (run_reg && (b_sh_reg != '0))
        begin
            acc_reg  <= acc_reg + pp;
            a_sh_reg <= a_sh_reg << 2;
            b_sh_reg <= b_sh_reg >> 2;
        end
    end

endmodule
`default_nettype wire

// ===== src/wohd_win.sv =====
// Sample ring memory with a sweep that sums the newest samples and their squares.
// Depends on wohd_pkg for the control struct.
`default_nettype none
module wohd_win #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16,
    localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
    localparam int CW    = $clog2(MAX_WINDOW + 1),
    localparam int SUM_W = SAMPLE_BITS + CW,
    localparam int SQ_W  = 2 * SAMPLE_BITS + CW
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire wohd_pkg::win_ctl_t     ctl,
    input  wire logic [SAMPLE_BITS-1:0] wr_data,
    input  wire logic [CW-1:0]          n_count,
    output logic                        done,
    output logic [SUM_W-1:0]            sum,
    output logic [SQ_W-1:0]             sq_sum,
    output logic [SUM_W-1:0]            front_sum,
    output logic [SQ_W-1:0]             front_sq_sum
);

    logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];

    logic [AW-1:0]            wp_reg;
    logic [AW-1:0]            rd_addr_reg;
    logic [CW-1:0]            left_reg;
    logic [CW-1:0]            k_reg;
    logic [CW-1:0]            half_reg;
    logic                     sweeping_reg;
    logic [SAMPLE_BITS-1:0]   rdata_reg;
    logic                     rd_v_reg;
    logic                     rd_front_reg;
    logic [SAMPLE_BITS-1:0]   x2_reg;
    logic [2*SAMPLE_BITS-1:0] sq2_reg;
    logic                     v2_reg;
    logic                     front2_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [SUM_W-1:0]         fsum_reg;
    logic [SQ_W-1:0]          fsq_reg;
    logic [CW:0]              start_wide;
    logic [AW-1:0]            start_addr;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        r = (p == AW'(MAX_WINDOW - 1)) ? '0 : p + AW'(1);
        return r;
    endfunction

    // The newest n samples end just below the write pointer.
    always_comb
    begin
        start_wide = (CW+1)'(wp_reg) + (CW+1)'(MAX_WINDOW) - (CW+1)'(n_count);
        if (start_wide >= (CW+1)'(MAX_WINDOW))
        begin
            start_wide = start_wide - (CW+1)'(MAX_WINDOW);
        end
        start_addr = start_wide[AW-1:0];
    end

    assign done         = sweeping_reg && (left_reg == '0) && !rd_v_reg && !v2_reg;
    assign sum          = sum_reg;
    assign sq_sum       = sq_reg;
    assign front_sum    = fsum_reg;
    assign front_sq_sum = fsq_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.write)
        begin
            mem[wp_reg] <= wr_data;
        end
        rdata_reg <= mem[rd_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            left_reg     <= '0;
            sweeping_reg <= 1'b0;
            rd_v_reg     <= 1'b0;
            v2_reg       <= 1'b0;
        end
        else
        begin
            if (ctl.write)
            begin
                wp_reg <= wrap_inc(wp_reg);
            end
            if (ctl.sweep)
            begin
                sweeping_reg <= 1'b1;
                left_reg     <= n_count;
                rd_v_reg     <= 1'b0;
            end
            else
            begin
                if (done)
                begin
                    sweeping_reg <= 1'b0;
                end
                rd_v_reg <= (left_reg != '0);
                if (left_reg != '0)
                begin
                    left_reg <= left_reg - CW'(1);
                end
            end
            v2_reg <= rd_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sweep)
        begin
            rd_addr_reg <= start_addr;
            k_reg       <= '0;
            half_reg    <= n_count >> 1;
            sum_reg     <= '0;
            sq_reg      <= '0;
            fsum_reg    <= '0;
            fsq_reg     <= '0;
        end
        else
        begin
            if (left_reg != '0)
            begin
                rd_addr_reg  <= wrap_inc(rd_addr_reg);
                k_reg        <= k_reg + CW'(1);
                rd_front_reg <= (k_reg < half_reg);
            end
            if (v2_reg)
            begin
                sum_reg <= sum_reg + SUM_W'(x2_reg);
                sq_reg  <= sq_reg + SQ_W'(sq2_reg);
                if (front2_reg)
                begin
                    fsum_reg <= fsum_reg + SUM_W'(x2_reg);
                    fsq_reg  <= fsq_reg + SQ_W'(sq2_reg);
                end
            end
        end
        x2_reg     <= rdata_reg;
        sq2_reg    <= rdata_reg * rdata_reg;
        front2_reg <= rd_front_reg;
    end

endmodule
`default_nettype wire

// ===== src/windowed_onset_hit_detector.sv =====
// Top level of the windowed onset hit detector: configuration, control sequencer, rules.
// Depends on wohd_pkg, wohd_win and wohd_mul.
//
// Usage. One energy word per frame enters on in_valid/in_ready; one hit word per
// frame leaves on out_valid/out_ready, in order. Registers are written on the
// cfg channel (cfg_index, cfg_data), which is always ready; write them only while
// the block is idle.
// Timing. A frame that is not tested (warmup, hold-off or window not yet full)
// goes from the decision state straight to the finish state, which loads the
// output register. A tested frame first sweeps the ring memory, one sample read
// per cycle, and then runs twenty products through one shared multiplier that
// retires two bits of its second operand per cycle, so the time a tested frame
// takes depends on how many bits the operands carry.
// One frame is in work at a time.
// A new frame is accepted while the previous hit word still waits at the output.
// If the receiver stalls, the finished frame waits in the sequencer and no new
// frame is taken until the output register is free.
// Reset clears all control state and loads the register defaults; the sample
// memory needs no clearing, since only written entries are ever swept.
`default_nettype none
module windowed_onset_hit_detector #(
    parameter int MAX_WINDOW  = wohd_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = wohd_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [wohd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [15:0]                      cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [15:0]                      energy,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  hit
);

    localparam int SB    = SAMPLE_BITS;
    localparam int CW    = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = SB + CW;
    localparam int SQ_W  = 2 * SB + CW;
    localparam int MW    = 2 * SUM_W + 2;
    localparam int PW    = 2 * MW;

    // Configuration registers.
    logic [6:0]  window_size_reg;
    logic [15:0] peak_thr_reg;
    logic [15:0] trend_thr_reg;
    logic [15:0] var_thr_reg;
    logic [15:0] refractory_reg;
    logic [15:0] warmup_reg;
    logic [2:0]  mode_reg;

    // Frame state.
    wohd_pkg::state_t    state_reg, state_next;
    wohd_pkg::mul_step_t step_reg;
    logic [CW-1:0]       fill_reg;
    logic [15:0]         frames_reg;
    logic [15:0]         holdoff_reg;
    logic                detect_reg;
    logic                eval_reg;
    logic [CW-1:0]       n_reg;
    logic [SB-1:0]       cur_reg;
    logic [2*SB-1:0]     cur_sq_reg;
    logic                out_valid_reg;
    logic                hit_reg;

    // Products kept between multiplier steps.
    logic [MW-1:0]        tmp_reg;
    logic [MW-1:0]        d_reg;
    logic signed [MW:0]   num_reg;
    logic [MW-1:0]        a2_reg;
    logic [PW-1:0]        plhs_reg;
    logic [MW-1:0]        t2_reg;
    logic [MW-1:0]        t2m_reg;
    logic [PW-1:0]        prhs_reg;
    logic [MW-1:0]        tx_reg;
    logic [MW-1:0]        ty_reg;
    logic [MW-1:0]        tyb_reg;
    logic [MW-1:0]        d1_reg;
    logic [MW-1:0]        d2_reg;
    logic [MW-1:0]        aa_reg;
    logic [PW-1:0]        vlhs_reg;
    logic [MW-1:0]        vb_reg;
    logic [MW-1:0]        vbb_reg;
    logic [PW-1:0]        vrhs_reg;

    logic               in_acc;
    logic               out_free;
    logic [CW-1:0]      w_eff;
    logic [SB-1:0]      cur_in;
    logic [CW-1:0]      fill_new;
    logic [15:0]        frames_new;
    logic [15:0]        holdoff_new;
    logic               detect_new;

    wohd_pkg::win_ctl_t win_ctl;
    logic               win_done;
    logic [SUM_W-1:0]   win_sum;
    logic [SQ_W-1:0]    win_sq;
    logic [SUM_W-1:0]   win_fsum;
    logic [SQ_W-1:0]    win_fsq;

    logic               mul_start;
    logic [MW-1:0]      mul_a;
    logic [MW-1:0]      mul_b;
    logic               mul_done;
    logic [PW-1:0]      mul_prod;

    logic [SUM_W-1:0]   s_val;
    logic [SQ_W-1:0]    q_val;
    logic [SUM_W-1:0]   s2_val;
    logic [SQ_W-1:0]    q2_val;
    logic [CW-1:0]      m_val;
    logic [CW-1:0]      a_val;
    logic [CW-1:0]      b_val;
    logic [MW-1:0]      anum;
    logic [15:0]        tmag;
    logic               num_pos;
    logic               thr_neg;
    logic               peak_ok;
    logic               trend_ok;
    logic               var_ok;
    logic               rule_hit;
    logic               hit_calc;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == wohd_pkg::ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign cur_in    = SB'(energy);

    // Effective window: zero counts as one, and it saturates at the memory depth.
    always_comb
    begin
        if (window_size_reg == 7'd0)
        begin
            w_eff = CW'(1);
        end
        else if (int'(window_size_reg) > MAX_WINDOW)
        begin
            w_eff = CW'(MAX_WINDOW);
        end
        else
        begin
            w_eff = CW'(window_size_reg);
        end
    end

    always_comb
    begin
        fill_new    = (fill_reg == CW'(MAX_WINDOW)) ? fill_reg : fill_reg + CW'(1);
        frames_new  = (frames_reg == 16'hFFFF) ? frames_reg : frames_reg + 16'd1;
        holdoff_new = (holdoff_reg != 16'd0) ? holdoff_reg - 16'd1 : holdoff_reg;
        detect_new  = detect_reg || (frames_new >= warmup_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= wohd_pkg::RST_WINDOW_SIZE;
            peak_thr_reg    <= wohd_pkg::RST_PEAK_THRESHOLD;
            trend_thr_reg   <= wohd_pkg::RST_TREND_THRESHOLD;
            var_thr_reg     <= wohd_pkg::RST_VARIANCE_THRESHOLD;
            refractory_reg  <= wohd_pkg::RST_REFRACTORY_FRAMES;
            warmup_reg      <= wohd_pkg::RST_WARMUP_FRAMES;
            mode_reg        <= wohd_pkg::RST_DETECTION_MODE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                wohd_pkg::CFG_WINDOW_SIZE:        window_size_reg <= cfg_data[6:0];
                wohd_pkg::CFG_PEAK_THRESHOLD:     peak_thr_reg    <= cfg_data;
                wohd_pkg::CFG_TREND_THRESHOLD:    trend_thr_reg   <= cfg_data;
                wohd_pkg::CFG_VARIANCE_THRESHOLD: var_thr_reg     <= cfg_data;
                wohd_pkg::CFG_REFRACTORY_FRAMES:  refractory_reg  <= cfg_data;
                wohd_pkg::CFG_WARMUP_FRAMES:      warmup_reg      <= cfg_data;
                wohd_pkg::CFG_DETECTION_MODE:     mode_reg        <= cfg_data[2:0];
                default:
                begin
                end
            endcase
        end
    end

    // Ring memory and window sums.
    assign win_ctl.write = in_acc;
    assign win_ctl.sweep = (state_reg == wohd_pkg::ST_DECIDE) && eval_reg;

    wohd_win #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_win (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (win_ctl),
        .wr_data      (cur_in),
        .n_count      (n_reg),
        .done         (win_done),
        .sum          (win_sum),
        .sq_sum       (win_sq),
        .front_sum    (win_fsum),
        .front_sq_sum (win_fsq)
    );

    wohd_mul #(
        .MW (MW),
        .PW (PW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // Window statistics. The peak rule looks at the samples before the current one.
    always_comb
    begin
        s_val  = win_sum - SUM_W'(cur_reg);
        q_val  = win_sq - SQ_W'(cur_sq_reg);
        s2_val = win_sum - win_fsum;
        q2_val = win_sq - win_fsq;
        m_val  = n_reg - CW'(1);
        a_val  = n_reg >> 1;
        b_val  = n_reg - a_val;
        anum   = num_reg[MW] ? MW'(-num_reg) : MW'(num_reg);
        tmag   = peak_thr_reg[15] ? (16'd0 - peak_thr_reg) : peak_thr_reg;
    end

    // Operands of each multiplier step.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            wohd_pkg::STEP_MQ:
            begin
                mul_a = MW'(m_val);
                mul_b = MW'(q_val);
            end
            wohd_pkg::STEP_SS:
            begin
                mul_a = MW'(s_val);
                mul_b = MW'(s_val);
            end
            wohd_pkg::STEP_MC:
            begin
                mul_a = MW'(cur_reg);
                mul_b = MW'(m_val);
            end
            wohd_pkg::STEP_A2:
            begin
                mul_a = anum;
                mul_b = anum;
            end
            wohd_pkg::STEP_LHS:
            begin
                mul_a = a2_reg;
                mul_b = MW'(m_val - CW'(1)) << 16;
            end
            wohd_pkg::STEP_T2:
            begin
                mul_a = MW'(tmag);
                mul_b = MW'(tmag);
            end
            wohd_pkg::STEP_T2M:
            begin
                mul_a = t2_reg;
                mul_b = MW'(m_val);
            end
            wohd_pkg::STEP_RHS:
            begin
                mul_a = t2m_reg;
                mul_b = d_reg;
            end
            wohd_pkg::STEP_TA:
            begin
                mul_a = MW'(s2_val);
                mul_b = MW'(a_val);
            end
            wohd_pkg::STEP_TB:
            begin
                mul_a = MW'(win_fsum);
                mul_b = MW'(trend_thr_reg);
            end
            wohd_pkg::STEP_TC:
            begin
                mul_a = ty_reg;
                mul_b = MW'(b_val);
            end
            wohd_pkg::STEP_V1:
            begin
                mul_a = MW'(win_fsq);
                mul_b = MW'(a_val);
            end
            wohd_pkg::STEP_V2:
            begin
                mul_a = MW'(win_fsum);
                mul_b = MW'(win_fsum);
            end
            wohd_pkg::STEP_V3:
            begin
                mul_a = MW'(q2_val);
                mul_b = MW'(b_val);
            end
            wohd_pkg::STEP_V4:
            begin
                mul_a = MW'(s2_val);
                mul_b = MW'(s2_val);
            end
            wohd_pkg::STEP_V5:
            begin
                mul_a = MW'(a_val);
                mul_b = MW'(a_val - CW'(1));
            end
            wohd_pkg::STEP_V6:
            begin
                mul_a = d2_reg;
                mul_b = aa_reg << 8;
            end
            wohd_pkg::STEP_V7:
            begin
                mul_a = MW'(var_thr_reg);
                mul_b = MW'(b_val);
            end
            wohd_pkg::STEP_V8:
            begin
                mul_a = vb_reg;
                mul_b = MW'(b_val - CW'(1));
            end
            wohd_pkg::STEP_V9:
            begin
                mul_a = d1_reg;
                mul_b = vbb_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == wohd_pkg::ST_MUL_WAIT) && mul_done)
        begin
            case (step_reg)
                wohd_pkg::STEP_MQ:   tmp_reg  <= mul_prod[MW-1:0];
                wohd_pkg::STEP_SS:   d_reg    <= tmp_reg - mul_prod[MW-1:0];
                wohd_pkg::STEP_MC:   num_reg  <= $signed({1'b0, mul_prod[MW-1:0]})
                                               - $signed((MW+1)'(s_val));
                wohd_pkg::STEP_A2:   a2_reg   <= mul_prod[MW-1:0];
                wohd_pkg::STEP_LHS:  plhs_reg <= mul_prod;
                wohd_pkg::STEP_T2:   t2_reg   <= mul_prod[MW-1:0];
                wohd_pkg::STEP_T2M:  t2m_reg  <= mul_prod[MW-1:0];
                wohd_pkg::STEP_RHS:  prhs_reg <= mul_prod;
                wohd_pkg::STEP_TA:   tx_reg   <= mul_prod[MW-1:0];
                wohd_pkg::STEP_TB:   ty_reg   <= mul_prod[MW-1:0];
                wohd_pkg::STEP_TC:   tyb_reg  <= mul_prod[MW-1:0];
                wohd_pkg::STEP_V1:   tmp_reg  <= mul_prod[MW-1:0];
                wohd_pkg::STEP_V2:   d1_reg   <= tmp_reg - mul_prod[MW-1:0];
                wohd_pkg::STEP_V3:   tmp_reg  <= mul_prod[MW-1:0];
                wohd_pkg::STEP_V4:   d2_reg   <= tmp_reg - mul_prod[MW-1:0];
                wohd_pkg::STEP_V5:   aa_reg   <= mul_prod[MW-1:0];
                wohd_pkg::STEP_V6:   vlhs_reg <= mul_prod;
                wohd_pkg::STEP_V7:   vb_reg   <= mul_prod[MW-1:0];
                wohd_pkg::STEP_V8:   vbb_reg  <= mul_prod[MW-1:0];
                wohd_pkg::STEP_V9:   vrhs_reg <= mul_prod;
                default:
                begin
                end
            endcase
        end
    end

    // Hit rules, evaluated on the finished products.
    always_comb
    begin
        num_pos  = !num_reg[MW] && (num_reg != '0);
        thr_neg  = peak_thr_reg[15];
        peak_ok  = (n_reg >= CW'(3)) && (d_reg != '0)
                   && ((num_pos && thr_neg)
                       || (!(!num_pos && !thr_neg)
                           && (num_pos ? (plhs_reg > prhs_reg) : (plhs_reg < prhs_reg))));
        if (win_fsum == '0)
        begin
            trend_ok = (n_reg >= CW'(4)) && (trend_thr_reg[15:8] == 8'd0);
        end
        else
        begin
            trend_ok = (n_reg >= CW'(4)) && ({tx_reg, 8'd0} > (MW+8)'(tyb_reg));
        end
        var_ok = (n_reg >= CW'(6)) && (d1_reg != '0) && (vlhs_reg > vrhs_reg);
        case (mode_reg)
            wohd_pkg::MODE_PEAK:     rule_hit = peak_ok;
            wohd_pkg::MODE_TREND:    rule_hit = trend_ok;
            wohd_pkg::MODE_VARIANCE: rule_hit = var_ok;
            wohd_pkg::MODE_VOTE:     rule_hit = (peak_ok && trend_ok) || (peak_ok && var_ok)
                                                || (trend_ok && var_ok);
            default:                 rule_hit = 1'b0;
        endcase
        hit_calc = eval_reg && rule_hit;
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        unique case (state_reg)
            wohd_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = wohd_pkg::ST_DECIDE;
                end
            end
            wohd_pkg::ST_DECIDE:
            begin
                state_next = eval_reg ? wohd_pkg::ST_SWEEP : wohd_pkg::ST_FINISH;
            end
            wohd_pkg::ST_SWEEP:
            begin
                if (win_done)
                begin
                    state_next = wohd_pkg::ST_MUL_GO;
                end
            end
            wohd_pkg::ST_MUL_GO:
            begin
                mul_start  = 1'b1;
                state_next = wohd_pkg::ST_MUL_WAIT;
            end
            wohd_pkg::ST_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = (step_reg == wohd_pkg::STEP_V9) ? wohd_pkg::ST_FINISH
                                                                  : wohd_pkg::ST_MUL_GO;
                end
            end
            wohd_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = wohd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wohd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wohd_pkg::ST_IDLE;
            step_reg      <= wohd_pkg::STEP_MQ;
            fill_reg      <= '0;
            frames_reg    <= '0;
            holdoff_reg   <= '0;
            detect_reg    <= 1'b0;
            eval_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
            begin
                fill_reg    <= fill_new;
                frames_reg  <= frames_new;
                holdoff_reg <= holdoff_new;
                detect_reg  <= detect_new;
                eval_reg    <= detect_new && (holdoff_new == 16'd0) && (fill_new >= w_eff);
            end
            if (state_reg == wohd_pkg::ST_SWEEP)
            begin
                step_reg <= wohd_pkg::STEP_MQ;
            end
            else if ((state_reg == wohd_pkg::ST_MUL_WAIT) && mul_done
                     && (step_reg != wohd_pkg::STEP_V9))
            begin
                step_reg <= wohd_pkg::mul_step_t'(step_reg + 5'd1);
            end
            if ((state_reg == wohd_pkg::ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (hit_calc)
                begin
                    holdoff_reg <= refractory_reg;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            n_reg   <= w_eff;
            cur_reg <= cur_in;
        end
        if (state_reg == wohd_pkg::ST_DECIDE)
        begin
            cur_sq_reg <= cur_reg * cur_reg;
        end
        if ((state_reg == wohd_pkg::ST_FINISH) && out_free)
        begin
            hit_reg <= hit_calc;
        end
    end

    // The sweep only reports completion while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        win_done |-> (state_reg == wohd_pkg::ST_SWEEP))
        else $error("window sweep finished outside the sweep state");

    // Products are only retired while the sequencer waits on the multiplier.
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == wohd_pkg::ST_MUL_WAIT))
        else $error("multiplier finished outside the wait state");

    // An accepted frame always moves on to the decision cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == wohd_pkg::ST_DECIDE))
        else $error("accepted frame did not reach the decision state");

    // A delivered hit reloads the hold-off counter.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == wohd_pkg::ST_FINISH) && out_free && hit_calc)
        |=> (holdoff_reg == $past(refractory_reg)) && hit_reg)
        else $error("hit did not reload the hold-off counter");

endmodule
`default_nettype wire
